FILE: rtl/core/stpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_pkg
// Shared types, codes and constants of the trapezoid step pulse generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

  localparam int unsigned TicksPerSecond = 1000000;
  localparam int unsigned TickW          = 20;
  localparam logic [TickW-1:0] TicksVal  = TickW'(TicksPerSecond);

  localparam int unsigned DivW    = 32;
  localparam int unsigned DsorW   = 16;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [6:0]  PctClamp   = 7'd50;

  // steps * percent / 100 as a reciprocal multiply, exact for products below 2^22
  localparam int unsigned RampProdW  = 22;
  localparam int unsigned RampRecipW = 23;
  localparam int unsigned RampMulW   = RampProdW + RampRecipW;
  localparam int unsigned RampShift  = 29;
  localparam logic [RampRecipW-1:0] RampRecip = 23'd5368710;

  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgMinFreq   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFreq   = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgAccelPct  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgPulseHigh = 4'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APPLY,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_TICK,
    ST_OUT
  } stpg_state_e;

  typedef enum logic {
    MUL_RAMP,
    MUL_RATE
  } mul_sel_e;

  typedef enum logic {
    DIV_RATE,
    DIV_PERIOD
  } div_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     apply_start;
    logic     set_rate;
    logic     begin_step;
    logic     tick;
    logic     out_load;
  } stpg_cmd_t;

  typedef struct packed {
    logic func;
    logic active;
    logic need_begin;
    logic ramp_zone;
    logic div_done;
    logic out_free;
  } stpg_status_t;

  // first member in the highest bits, step_level ends up in bit 0
  typedef struct packed {
    logic [15:0] steps_done;
    logic [15:0] rate_now;
    logic        busy_res;
    logic        enable_n;
    logic        dir_level;
    logic        step_level;
  } stpg_result_t;

endpackage

FILE: rtl/core/stpg_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_divider
// Restoring serial divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module stpg_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [stpg_pkg::DivW-1:0]     dividend_i,
  input  logic [stpg_pkg::DsorW-1:0]    divisor_i,
  output logic [stpg_pkg::DivW-1:0]     quotient_o,
  output logic                          done_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [stpg_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [stpg_pkg::DivW-1:0]      work_q, work_d;
  logic [stpg_pkg::DsorW:0]       rem_q, rem_d;
  logic [stpg_pkg::DsorW-1:0]     dsor_q, dsor_d;
  logic [stpg_pkg::DsorW:0]       rem_shift;
  logic [stpg_pkg::DsorW:0]       rem_sub;
  logic                           fits;

  always_comb begin
    rem_shift = {rem_q[stpg_pkg::DsorW-1:0], work_q[stpg_pkg::DivW-1]};
    fits      = rem_shift >= {1'b0, dsor_q};
    rem_sub   = rem_shift - {1'b0, dsor_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    work_d    = work_q;
    rem_d     = rem_q;
    dsor_d    = dsor_q;
    if (start_i) begin
      work_d = dividend_i;
      dsor_d = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? rem_sub : rem_shift;
      work_d = {work_q[stpg_pkg::DivW-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == stpg_pkg::DivCntW'(stpg_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dsor_q <= dsor_d;
  end

  assign quotient_o = work_q;
  assign done_o     = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");

  a_done_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##33 done_q) else $error("divider done pulse out of place");

endmodule

FILE: rtl/core/stpg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_datapath
// Settings, move state, ramp arithmetic, shared divider and result register.
// ----------------------------------------------------------------------------
module stpg_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stpg_pkg::stpg_cmd_t              cmd_i,
  output stpg_pkg::stpg_status_t           status_o,
  input  logic                             cfg_valid_i,
  input  logic [stpg_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             func_i,
  input  logic [15:0]                      move_steps_i,
  input  logic                             move_direction_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output stpg_pkg::stpg_result_t           result_o
);

  // settings
  logic [15:0] min_freq_q, max_freq_q, pulse_high_q;
  logic [6:0]  accel_pct_q;

  // latched item
  logic        func_q;
  logic [15:0] steps_in_q;
  logic        dir_in_q;

  // move state
  logic [15:0]                 total_steps_q, total_steps_d;
  logic [15:0]                 step_index_q, step_index_d;
  logic [15:0]                 ramp_steps_q, ramp_steps_d;
  logic [stpg_pkg::TickW-1:0]  phase_timer_q, phase_timer_d;
  logic [stpg_pkg::TickW-1:0]  low_time_q, low_time_d;
  logic                        pulse_high_phase_q, pulse_high_phase_d;
  logic [15:0]                 current_rate_q, current_rate_d;
  logic                        direction_q, direction_d;
  logic                        level_q, level_d;

  logic [31:0]                 prod_q;
  logic                        out_valid_q;
  stpg_pkg::stpg_result_t      out_q;

  // arithmetic
  logic [15:0]                 diff;
  logic                        in_accel, in_decel, ramp_zone;
  logic [15:0]                 decel_base, k_val;
  logic [6:0]                  pct;
  logic [15:0]                 mul_a, mul_b;
  logic [stpg_pkg::RampMulW-1:0] ramp_prod;
  logic [15:0]                 ramp_new;
  logic [stpg_pkg::DivW-1:0]   div_num;
  logic [stpg_pkg::DsorW-1:0]  div_den;
  logic [stpg_pkg::DivW-1:0]   quot;
  logic                        div_done;
  logic [15:0]                 q16;
  logic [16:0]                 accel_sum;
  logic [15:0]                 decel_rate, raw_rate, new_rate;
  logic [stpg_pkg::TickW-1:0]  period, pulse_ext, low_new, timer_new, timer_dec;

  always_comb begin
    diff       = (max_freq_q >= min_freq_q) ? (max_freq_q - min_freq_q) : 16'd0;
    decel_base = total_steps_q - ramp_steps_q;
    in_accel   = step_index_q < ramp_steps_q;
    in_decel   = step_index_q >= decel_base;
    ramp_zone  = (ramp_steps_q != 16'd0) && (in_accel || in_decel);
    k_val      = in_accel ? (step_index_q + 16'd1) : (step_index_q - decel_base);
    pct        = (accel_pct_q > stpg_pkg::PctClamp) ? stpg_pkg::PctClamp : accel_pct_q;
    if (cmd_i.mul_sel == stpg_pkg::MUL_RAMP) begin
      mul_a = steps_in_q;
      mul_b = {9'd0, pct};
    end else begin
      mul_a = diff;
      mul_b = k_val;
    end
    ramp_prod = {{stpg_pkg::RampRecipW{1'b0}}, prod_q[stpg_pkg::RampProdW-1:0]} *
                {{stpg_pkg::RampProdW{1'b0}}, stpg_pkg::RampRecip};
    ramp_new  = ramp_prod[stpg_pkg::RampShift +: 16];
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      stpg_pkg::DIV_RATE: begin
        div_num = prod_q;
        div_den = ramp_steps_q;
      end
      stpg_pkg::DIV_PERIOD: begin
        div_num = {{(stpg_pkg::DivW - stpg_pkg::TickW){1'b0}}, stpg_pkg::TicksVal};
        div_den = current_rate_q;
      end
    endcase
  end

  stpg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  always_comb begin
    q16        = quot[15:0];
    accel_sum  = {1'b0, min_freq_q} + {1'b0, q16};
    decel_rate = (max_freq_q >= q16) ? (max_freq_q - q16) : 16'd0;
    if (!ramp_zone) begin
      raw_rate = max_freq_q;
    end else if (in_accel) begin
      raw_rate = accel_sum[16] ? 16'hFFFF : accel_sum[15:0];
    end else begin
      raw_rate = decel_rate;
    end
    new_rate  = (raw_rate == 16'd0) ? 16'd1 : raw_rate;
    period    = quot[stpg_pkg::TickW-1:0];
    pulse_ext = {{(stpg_pkg::TickW - 16){1'b0}}, pulse_high_q};
    low_new   = (period > pulse_ext) ? (period - pulse_ext) : '0;
    timer_new = (pulse_high_q == 16'd0) ? stpg_pkg::TickW'(1) : pulse_ext;
    timer_dec = phase_timer_q - 1'b1;
  end

  always_comb begin
    total_steps_d      = total_steps_q;
    step_index_d       = step_index_q;
    ramp_steps_d       = ramp_steps_q;
    phase_timer_d      = phase_timer_q;
    low_time_d         = low_time_q;
    pulse_high_phase_d = pulse_high_phase_q;
    current_rate_d     = current_rate_q;
    direction_d        = direction_q;
    level_d            = level_q;
    if (cmd_i.load_item) begin
      level_d = 1'b0;
    end
    if (cmd_i.apply_start) begin
      total_steps_d      = steps_in_q;
      direction_d        = dir_in_q;
      step_index_d       = '0;
      ramp_steps_d       = ramp_new;
      phase_timer_d      = '0;
      low_time_d         = '0;
      pulse_high_phase_d = 1'b0;
      current_rate_d     = '0;
    end
    if (cmd_i.set_rate) begin
      current_rate_d = new_rate;
    end
    if (cmd_i.begin_step) begin
      low_time_d         = low_new;
      pulse_high_phase_d = 1'b1;
      phase_timer_d      = timer_new;
    end
    if (cmd_i.tick) begin
      phase_timer_d = timer_dec;
      if (pulse_high_phase_q) begin
        level_d = 1'b1;
        if (timer_dec == '0) begin
          pulse_high_phase_d = 1'b0;
          phase_timer_d      = low_time_q;
          if (low_time_q == '0) begin
            step_index_d = step_index_q + 16'd1;
          end
        end
      end else if (timer_dec == '0) begin
        step_index_d = step_index_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q         <= 16'd200;
      max_freq_q         <= 16'd1000;
      accel_pct_q        <= 7'd20;
      pulse_high_q       <= 16'd10;
      total_steps_q      <= '0;
      step_index_q       <= '0;
      ramp_steps_q       <= '0;
      phase_timer_q      <= '0;
      low_time_q         <= '0;
      pulse_high_phase_q <= 1'b0;
      current_rate_q     <= '0;
      direction_q        <= 1'b1;
      level_q            <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          stpg_pkg::CfgMinFreq:   min_freq_q   <= cfg_data_i;
          stpg_pkg::CfgMaxFreq:   max_freq_q   <= cfg_data_i;
          stpg_pkg::CfgAccelPct:  accel_pct_q  <= cfg_data_i[6:0];
          stpg_pkg::CfgPulseHigh: pulse_high_q <= cfg_data_i;
          default: ;
        endcase
      end
      total_steps_q      <= total_steps_d;
      step_index_q       <= step_index_d;
      ramp_steps_q       <= ramp_steps_d;
      phase_timer_q      <= phase_timer_d;
      low_time_q         <= low_time_d;
      pulse_high_phase_q <= pulse_high_phase_d;
      current_rate_q     <= current_rate_d;
      direction_q        <= direction_d;
      level_q            <= level_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q     <= func_i;
      steps_in_q <= move_steps_i;
      dir_in_q   <= move_direction_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.out_load) begin
      out_q.step_level <= level_q;
      out_q.dir_level  <= direction_q;
      out_q.enable_n   <= step_index_q == total_steps_q;
      out_q.busy_res   <= step_index_q != total_steps_q;
      out_q.rate_now   <= current_rate_q;
      out_q.steps_done <= step_index_q;
    end
  end

  assign status_o.func       = func_q;
  assign status_o.active     = step_index_q != total_steps_q;
  assign status_o.need_begin = !pulse_high_phase_q && (phase_timer_q == '0);
  assign status_o.ramp_zone  = ramp_zone;
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_index_q <= total_steps_q) else $error("step index past move length");

  a_high_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_high_phase_q |-> phase_timer_q != '0) else $error("high phase with empty timer");

endmodule

FILE: rtl/core/stpg_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_controller
// Sequencer: decodes an item and steps the datapath through its operations.
// ----------------------------------------------------------------------------
module stpg_controller (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  stpg_pkg::stpg_status_t  status_i,
  output stpg_pkg::stpg_cmd_t     cmd_o
);

  stpg_pkg::stpg_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stpg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = stpg_pkg::ST_DECODE;
      end
      stpg_pkg::ST_DECODE: begin
        if (status_i.func) begin
          state_d = stpg_pkg::ST_APPLY;
        end else if (!status_i.active) begin
          state_d = stpg_pkg::ST_OUT;
        end else if (!status_i.need_begin) begin
          state_d = stpg_pkg::ST_TICK;
        end else if (status_i.ramp_zone) begin
          state_d = stpg_pkg::ST_RATE_GO;
        end else begin
          state_d = stpg_pkg::ST_PER_GO;
        end
      end
      stpg_pkg::ST_APPLY:     state_d = stpg_pkg::ST_OUT;
      stpg_pkg::ST_RATE_GO:   state_d = stpg_pkg::ST_RATE_WAIT;
      stpg_pkg::ST_RATE_WAIT: begin
        if (status_i.div_done) state_d = stpg_pkg::ST_PER_GO;
      end
      stpg_pkg::ST_PER_GO:    state_d = stpg_pkg::ST_PER_WAIT;
      stpg_pkg::ST_PER_WAIT: begin
        if (status_i.div_done) state_d = stpg_pkg::ST_TICK;
      end
      stpg_pkg::ST_TICK:      state_d = stpg_pkg::ST_OUT;
      stpg_pkg::ST_OUT: begin
        if (status_i.out_free) state_d = stpg_pkg::ST_IDLE;
      end
      default:                state_d = stpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      stpg_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      stpg_pkg::ST_DECODE: begin
        if (status_i.func) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = stpg_pkg::MUL_RAMP;
        end else if (status_i.active && status_i.need_begin) begin
          if (status_i.ramp_zone) begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = stpg_pkg::MUL_RATE;
          end else begin
            cmd_o.set_rate = 1'b1;
          end
        end
      end
      stpg_pkg::ST_APPLY: begin
        cmd_o.apply_start = 1'b1;
      end
      stpg_pkg::ST_RATE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = stpg_pkg::DIV_RATE;
      end
      stpg_pkg::ST_RATE_WAIT: begin
        cmd_o.div_sel  = stpg_pkg::DIV_RATE;
        cmd_o.set_rate = status_i.div_done;
      end
      stpg_pkg::ST_PER_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = stpg_pkg::DIV_PERIOD;
      end
      stpg_pkg::ST_PER_WAIT: begin
        cmd_o.div_sel    = stpg_pkg::DIV_PERIOD;
        cmd_o.begin_step = status_i.div_done;
      end
      stpg_pkg::ST_TICK: begin
        cmd_o.tick = 1'b1;
      end
      stpg_pkg::ST_OUT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stpg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_item_decoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == stpg_pkg::ST_DECODE)
    else $error("accepted item not decoded");

endmodule

FILE: rtl/core/stepper_trapezoid_pulse_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_pulse_generator
// Step/direction pulse generator with a trapezoidal speed ramp.
// ----------------------------------------------------------------------------
// Input stream: tuser bit 0 selects a one-microsecond tick (0) or a move
// start (1); tdata carries the step count and direction used on a start.
// Every input transfer gives exactly one output transfer with the step pin
// level, direction pin, active-low enable, busy flag, current step rate and
// steps done. Settings are written over the cfg channel (always ready);
// the user must write them only while no item is in flight; the block
// itself does not enforce it. A tick passes decode and, inside a step, a
// tick state; a start passes an apply state; a tick that opens a step
// first runs the shared serial divider, one quotient bit per cycle, for
// the period, and on a ramp before that for the rate.
// Reset clears the move and loads the default settings; no clearing pass.
// A stalled output keeps its result in the output register; the next
// item is already taken in and worked on, and waits only for its own
// result to be loaded once that register is free.
// ----------------------------------------------------------------------------
module stepper_trapezoid_pulse_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] move_steps, [16] move_direction, [23:17] zero
  input  logic [23:0]                   s_axis_tdata,
  // [0] func
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] step_level, [1] dir_level, [2] enable_n, [3] busy_res,
  // [19:4] rate_now, [35:20] steps_done, [39:36] zero
  output logic [39:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stpg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  stpg_pkg::stpg_cmd_t    cmd;
  stpg_pkg::stpg_status_t status;
  stpg_pkg::stpg_result_t result;

  stpg_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stpg_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (s_axis_tuser[0]),
    .move_steps_i     (s_axis_tdata[15:0]),
    .move_direction_i (s_axis_tdata[16]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .result_o         (result)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {4'd0, result};

endmodule

FILE: test/stepper_trapezoid_pulse_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_pulse_generator_tb
// Self-checking bench for the trapezoid step pulse generator. Tick and move
// start transfers go into the input stream and each output transfer is
// compared field by field against a behavioral model of the step timing and
// ramp profile. Directed moves cover the idle, zero-length, abort, clamped
// and degenerate settings; random moves run at high step rates so that many
// complete ramps pass through, with random bursts of idling on both streams;
// a separate test adds one long output hold-off.
// ----------------------------------------------------------------------------
module stepper_trapezoid_pulse_generator_tb;

  localparam int unsigned TICKS_PER_SEC  = 1000000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned TAIL_CYCLES    = 100;
  localparam int unsigned ITEMS_END      = 1200;
  localparam int unsigned CALM_AFTER     = 980;

  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] steps_done;
    logic [15:0] rate_now;
    logic        busy_res;
    logic        enable_n;
    logic        dir_level;
    logic        step_level;
  } motion_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // [15:0] move_steps, [16] move_direction, [23:17] zero
  logic [23:0] s_axis_tdata;
  // [0] func
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // [0] step_level, [1] dir_level, [2] enable_n, [3] busy_res,
  // [19:4] rate_now, [35:20] steps_done, [39:36] zero
  logic [39:0] m_axis_tdata;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [stpg_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  stepper_trapezoid_pulse_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // settings as seen by the motion model
  logic [15:0] set_fmin  = 16'd200;
  logic [15:0] set_fmax  = 16'd1000;
  logic [6:0]  set_pct   = 7'd20;
  logic [15:0] set_pulse = 16'd10;

  // motion model state
  logic [15:0] move_len   = '0;
  logic [15:0] step_cnt   = '0;
  logic [15:0] ramp_len   = '0;
  logic [19:0] phase_left = '0;
  logic [19:0] low_len    = '0;
  logic        in_high    = 1'b0;
  logic [15:0] rate_q     = '0;
  logic        dir_q      = 1'b1;

  motion_out_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  logic        gaps_on = 1'b1;
  logic        hold_request = 1'b0;

  function automatic logic [15:0] profile_rate(input logic [15:0] idx);
    longint unsigned diff, lo, hi, rmp, tot, f, dec;
    lo  = 64'(set_fmin);
    hi  = 64'(set_fmax);
    rmp = 64'(ramp_len);
    tot = 64'(move_len);
    diff = (hi >= lo) ? hi - lo : 0;
    if (rmp == 0) begin
      f = hi;
    end else if (idx < rmp) begin
      f = lo + (diff * (longint'(idx) + 1)) / rmp;
    end else if (idx >= tot - rmp) begin
      dec = (diff * (longint'(idx) - (tot - rmp))) / rmp;
      f = (dec <= hi) ? hi - dec : 0;
    end else begin
      f = hi;
    end
    if (f > 65535) f = 65535;
    if (f == 0) f = 1;
    return f[15:0];
  endfunction

  function automatic motion_out_t motion_step(input bit is_start, input logic [15:0] steps,
                                              input bit dir);
    motion_out_t r;
    int unsigned pct_eff, period;
    logic lvl;
    lvl = 1'b0;
    if (is_start) begin
      pct_eff    = (set_pct > 7'd50) ? 50 : 32'(set_pct);
      move_len   = steps;
      dir_q      = dir;
      step_cnt   = '0;
      ramp_len   = 16'((int'(steps) * pct_eff) / 100);
      phase_left = '0;
      low_len    = '0;
      in_high    = 1'b0;
      rate_q     = '0;
    end else if (step_cnt != move_len) begin
      if (!in_high && phase_left == '0) begin
        rate_q     = profile_rate(step_cnt);
        period     = TICKS_PER_SEC / rate_q;
        low_len    = (period > set_pulse) ? 20'(period - set_pulse) : '0;
        in_high    = 1'b1;
        phase_left = (set_pulse == '0) ? 20'd1 : 20'(set_pulse);
      end
      if (in_high) begin
        lvl = 1'b1;
        phase_left = phase_left - 1'b1;
        if (phase_left == '0) begin
          in_high    = 1'b0;
          phase_left = low_len;
          if (low_len == '0) step_cnt = step_cnt + 1'b1;
        end
      end else begin
        phase_left = phase_left - 1'b1;
        if (phase_left == '0) step_cnt = step_cnt + 1'b1;
      end
    end
    r.pad        = '0;
    r.steps_done = step_cnt;
    r.rate_now   = rate_q;
    r.busy_res   = (step_cnt != move_len);
    r.enable_n   = (step_cnt == move_len);
    r.dir_level  = dir_q;
    r.step_level = lvl;
    return r;
  endfunction

  function automatic bit motion_busy();
    return step_cnt != move_len;
  endfunction

  function automatic void compare_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input bit is_start, input logic [15:0] steps, input bit dir);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, dir, steps};
    s_axis_tuser  <= is_start;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(motion_step(is_start, steps, dir));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(1'b0, 16'($urandom), 1'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] fmin, input logic [15:0] fmax,
                              input logic [6:0] pct, input logic [15:0] pulse);
    logic [stpg_pkg::CfgIdxW-1:0] idx [4];
    logic [15:0] val [4];
    drain_results();
    idx = '{stpg_pkg::CfgMinFreq, stpg_pkg::CfgMaxFreq, stpg_pkg::CfgAccelPct,
            stpg_pkg::CfgPulseHigh};
    val = '{fmin, fmax, 16'(pct), pulse};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        stpg_pkg::CfgMinFreq:   set_fmin  = val[k];
        stpg_pkg::CfgMaxFreq:   set_fmax  = val[k];
        stpg_pkg::CfgAccelPct:  set_pct   = val[k][6:0];
        stpg_pkg::CfgPulseHigh: set_pulse = val[k];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // high step rates keep a step within a few dozen ticks
  task automatic program_fast_settings();
    logic [15:0] fmin, fmax, pulse;
    logic [6:0] pct;
    int sel;
    fmin = 16'($urandom_range(40000, 65535));
    if ($urandom_range(0, 7) == 0) fmax = 16'($urandom_range(30000, fmin));
    else fmax = 16'($urandom_range(fmin, 65535));
    sel = $urandom_range(0, 11);
    if (sel == 0) pct = 7'd0;
    else if (sel == 1) pct = 7'd50;
    else if (sel == 2) pct = 7'd100;
    else pct = 7'($urandom_range(0, 100));
    sel = $urandom_range(0, 19);
    if (sel == 0) pulse = '0;
    else if (sel < 4) pulse = 16'($urandom_range(13, 40));
    else pulse = 16'($urandom_range(1, 12));
    program_regs(fmin, fmax, pct, pulse);
  endtask

  task automatic run_move(input logic [15:0] steps, input bit dir, input int max_ticks);
    int n;
    n = 0;
    send_item(1'b1, steps, dir);
    while (motion_busy() && n < max_ticks) begin
      send_tick();
      n++;
    end
  endtask

  task automatic test_directed();
    send_tick();
    send_item(1'b1, 16'd0, 1'b0);
    send_tick();
    send_item(1'b1, 16'd3, 1'b1);
    repeat (12) send_tick();
    send_item(1'b1, 16'hffff, 1'b0);
    repeat (2) send_tick();
    // max zero and below min, accel clamped, zero pulse width
    program_regs(16'd200, 16'd0, 7'd100, 16'd0);
    send_item(1'b1, 16'd1, 1'b1);
    repeat (2) send_tick();
    send_item(1'b1, 16'd4, 1'b0);
    repeat (2) send_tick();
  endtask

  task automatic test_config_extremes();
    program_regs(16'd1, 16'hffff, 7'd50, 16'hffff);
    run_move(16'hffff, 1'b1, 3);
    program_regs(16'hffff, 16'hffff, 7'd0, 16'd1);
    run_move(16'd2, 1'b0, 100);
    program_regs(16'd1, 16'd1, 7'd100, 16'd0);
    run_move(16'd3, 1'b1, 2);
  endtask

  task automatic test_output_backpressure();
    program_regs(16'd60000, 16'hffff, 7'd30, 16'd4);
    hold_request <= 1'b1;
    run_move(16'd10, 1'b0, 400);
  endtask

  task automatic test_random_moves();
    int unsigned limit, cfg_at, n;
    logic [15:0] steps;
    int sel;
    while (items_sent < ITEMS_END) begin
      program_fast_settings();
      repeat ($urandom_range(2, 5)) begin
        gaps_on <= (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 99);
        limit = 100000;
        cfg_at = 100000;
        if (sel < 5) begin
          steps = '0;
        end else if (sel < 85) begin
          steps = 16'($urandom_range(1, 6));
        end else if (sel < 95) begin
          steps = 16'($urandom_range(7, 16));
        end else begin
          steps = 16'($urandom);
          limit = $urandom_range(0, 30);
        end
        if (sel >= 5 && sel < 95 && $urandom_range(0, 6) == 0) limit = $urandom_range(0, 60);
        if ($urandom_range(0, 9) == 0) cfg_at = $urandom_range(1, 40);
        send_item(1'b1, steps, 1'($urandom));
        n = 0;
        while (motion_busy() && n < limit) begin
          if (n == cfg_at) program_fast_settings();
          send_tick();
          n++;
        end
        repeat ($urandom_range(0, 2)) send_tick();
      end
    end
  endtask

  // output side: random stalls, one long hold-off on request, result checking
  initial begin
    int hold_left;
    int stall_left;
    motion_out_t got, want;
    hold_left = 0;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_q.size() == 0) begin
          $error("output transfer with no result pending");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          compare_field("step_level", want.step_level, got.step_level);
          compare_field("dir_level", want.dir_level, got.dir_level);
          compare_field("enable_n", want.enable_n, got.enable_n);
          compare_field("busy_res", want.busy_res, got.busy_res);
          compare_field("rate_now", want.rate_now, got.rate_now);
          compare_field("steps_done", want.steps_done, got.steps_done);
          compare_field("pad", want.pad, got.pad);
        end
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** stepper_trapezoid_pulse_generator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_output_backpressure();
    test_random_moves();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** stepper_trapezoid_pulse_generator: PASSED **");
    end else begin
      $display("** stepper_trapezoid_pulse_generator: FAILED **");
    end
    $finish;
  end

endmodule
